@@ design/rmg_pkg.sv @@
// Shared types, codes and the quarter-wave sine table of the mesh generator.
`timescale 1ns / 1ps
package rmg_pkg;

  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 13;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_VERTEX  = 2'd1,
    CMD_FACE    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NO_CAP = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  localparam logic [1:0] SHAPE_CYL    = 2'd0;
  localparam logic [1:0] SHAPE_CONE   = 2'd1;
  localparam logic [1:0] SHAPE_SPHERE = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_AXIS = 2'd2;

  localparam logic [CFG_W-1:0] RING_COUNT_RST = 7'd16;
  localparam logic [1:0]       SHAPE_KIND_RST = SHAPE_CYL;
  localparam logic [1:0]       SWEEP_AXIS_RST = AXIS_Y;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } point_t;

  typedef struct packed {
    cmd_e                      cmd;
    point_t                    pt;
    logic [INDEX_W-1:0]        query_index;
  } item_t;

  typedef struct packed {
    status_e                   status;
    logic                      is_face;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic [INDEX_W-1:0]        corner_a;
    logic [INDEX_W-1:0]        corner_b;
    logic [INDEX_W-1:0]        corner_c;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] ring_count;
    logic [1:0]       shape_kind;
    logic [1:0]       sweep_axis;
  } cfg_t;

  // Q1.15 quarter wave, 64 steps plus the end point
  localparam logic [15:0] QSINE [0:64] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

endpackage

@@ design/rmg_front.sv @@
// Input side: accepts items, decodes the command and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module rmg_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic [1:0]                             cmd_i,
  input  logic signed [rmg_pkg::COORD_W-1:0]     px_i,
  input  logic signed [rmg_pkg::COORD_W-1:0]     py_i,
  input  logic signed [rmg_pkg::COORD_W-1:0]     pz_i,
  input  logic [rmg_pkg::INDEX_W-1:0]            query_index_i,
  output logic                                   item_valid_o,
  output rmg_pkg::item_t                         item_o,
  input  logic                                   item_take_i
);

  rmg_pkg::item_t entry_q [2];
  rmg_pkg::item_t item_in;
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push_acc;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign push_acc     = push_i && !full_o;
  assign item_o       = entry_q[rd_q];

  always_comb begin
    item_in.cmd         = rmg_pkg::cmd_e'(cmd_i);
    item_in.pt.px       = px_i;
    item_in.pt.py       = py_i;
    item_in.pt.pz       = pz_i;
    item_in.query_index = query_index_i;
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      entry_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_acc) begin
        wr_q <= ~wr_q;
      end
      if (item_take_i) begin
        rd_q <= ~rd_q;
      end
      unique case ({push_acc, item_take_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ design/rmg_back.sv @@
// Execution side: profile store, shared divider, square root, rotation and face indexing.
`timescale 1ns / 1ps
module rmg_back #(
  parameter int MAX_PROFILE = 64,
  parameter int MAX_RINGS   = 64,
  parameter int ANGLE_BITS  = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rmg_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  rmg_pkg::item_t   item_i,
  output logic             item_take_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rmg_pkg::result_t result_o
);

  localparam int PB   = $clog2(MAX_PROFILE + 1);
  localparam int IW   = $clog2(MAX_PROFILE);
  localparam int RB   = $clog2(MAX_RINGS + 1);
  localparam int QB   = ANGLE_BITS - 2;
  localparam int DW   = (RB + ANGLE_BITS > rmg_pkg::INDEX_W) ? RB + ANGLE_BITS
                                                             : rmg_pkg::INDEX_W;
  localparam int DDW  = (PB + 1 > RB) ? PB + 1 : RB;
  localparam int CW   = (PB + RB + 2 > rmg_pkg::INDEX_W + 1) ? PB + RB + 2
                                                             : rmg_pkg::INDEX_W + 1;
  localparam int DCNT = $clog2(DW);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SETUP = 13'b0000000000010,
    S_ROUTE = 13'b0000000000100,
    S_DIVQ  = 13'b0000000001000,
    S_DIVA  = 13'b0000000010000,
    S_TRIG  = 13'b0000000100000,
    S_MUL1  = 13'b0000001000000,
    S_MUL2  = 13'b0000010000000,
    S_PLACE = 13'b0000100000000,
    S_SQRT  = 13'b0001000000000,
    S_CAP   = 13'b0010000000000,
    S_DIVF  = 13'b0100000000000,
    S_FACE  = 13'b1000000000000
  } state_e;

  typedef struct packed {
    rmg_pkg::cmd_e              cmd;
    logic [rmg_pkg::INDEX_W-1:0] qi;
    logic [1:0]                 kind;
    logic [RB-1:0]              rings;
    logic [PB-1:0]              na;
    logic [CW-1:0]              nring;
    logic [CW-1:0]              sides;
    logic [PB:0]                per;
    logic                       bot;
    logic                       top;
    logic                       too_short;
    logic [31:0]                x0sq;
    logic [31:0]                y0sq;
    logic [DW-1:0]              dnum;
    logic [DW-1:0]              dquo;
    logic [DDW-1:0]             dden;
    logic [DDW-1:0]             drem;
    logic [DCNT-1:0]            dcnt;
    logic [RB-1:0]              j;
    logic [IW-1:0]              i;
    logic                       par;
    logic [ANGLE_BITS-1:0]      p;
    logic signed [16:0]         sn;
    logic signed [16:0]         cs;
    logic signed [32:0]         pr1;
    logic signed [32:0]         pr2;
    logic signed [15:0]         a;
    logic [31:0]                sv;
    logic [31:0]                sres;
    logic [3:0]                 scnt;
  } work_t;

  function automatic logic signed [16:0] tsin(input logic [ANGLE_BITS-1:0] ph);
    logic [1:0]       quad;
    logic [QB:0]      u;
    logic [QB+6:0]    t;
    logic [6:0]       idx;
    logic [QB-1:0]    fr;
    logic [15:0]      lo, hi;
    logic [QB+9:0]    prod;
    logic [16:0]      mag;
    quad = ph[ANGLE_BITS-1:ANGLE_BITS-2];
    u    = quad[0] ? (QB+1)'(2**QB) - {1'b0, ph[QB-1:0]} : {1'b0, ph[QB-1:0]};
    t    = {u, 6'b0};
    idx  = 7'(t >> QB);
    fr   = t[QB-1:0];
    if (idx >= 7'd64) begin
      mag = 17'd32768;
    end else begin
      lo   = rmg_pkg::QSINE[idx];
      hi   = rmg_pkg::QSINE[idx + 7'd1];
      prod = (QB+10)'(hi - lo) * (QB+10)'(fr);
      mag  = 17'(lo) + 17'(prod >> QB);
    end
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  // round half up, drop 15 fraction bits, saturate
  function automatic logic signed [15:0] rnd15(input logic signed [33:0] v);
    logic signed [33:0] w;
    logic signed [18:0] sh;
    w  = v + 34'sd16384;
    sh = 19'(w >>> 15);
    if (sh > 19'sd32767) begin
      return 16'sh7fff;
    end else if (sh < -19'sd32768) begin
      return 16'sh8000;
    end
    return 16'(sh);
  endfunction

  function automatic rmg_pkg::point_t place(input logic [1:0] axis,
                                           input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic signed [15:0] h);
    rmg_pkg::point_t r;
    if (axis == rmg_pkg::AXIS_X) begin
      r = '{px: h, py: a, pz: b};
    end else if (axis == rmg_pkg::AXIS_Y) begin
      r = '{px: a, py: h, pz: b};
    end else begin
      r = '{px: b, py: a, pz: h};
    end
    return r;
  endfunction

  rmg_pkg::point_t  mem [MAX_PROFILE];
  rmg_pkg::point_t  rd_q;
  logic signed [15:0] p0x_q, p0y_q, p1y_q, lastx_q, lasty_q;

  state_e           state_q, state_d;
  logic [PB-1:0]    len_q, len_d;
  logic             out_valid_q, out_valid_d;
  rmg_pkg::result_t out_q, out_d;
  work_t            w_q, w_d;

  logic             take, emit, append_ok;
  rmg_pkg::result_t res_c;

  // setup values
  logic [1:0]       kind_c;
  logic [RB-1:0]    rings_c;
  logic [PB-1:0]    na_c;
  logic [PB:0]      per_c;

  // divider step
  logic [DDW:0]     rs;
  logic             ge, dlast;
  logic [DDW-1:0]   rem_n;
  logic [DW-1:0]    quo_n;

  // square root step
  logic [31:0]      sbit, strial;

  // face indexing
  logic [CW-1:0]    qx, fo, fsel, m_a, m_b, ia, off;
  logic [RB:0]      jn_w, fn_w;
  logic [RB-1:0]    jn, fselr, fn;
  logic             in_sides, isbot, found;
  logic signed [15:0] b_c, h_c;

  assign take        = (state_q == S_IDLE) && item_valid_i && (!out_valid_q || pop_i);
  assign item_take_o = take;
  assign empty_o     = !out_valid_q;
  assign result_o    = out_q;
  assign append_ok   = (len_q != PB'(MAX_PROFILE));
  assign qx          = CW'(w_q.qi);

  always_comb begin
    kind_c = (cfg_i.shape_kind == rmg_pkg::SHAPE_CONE ||
              cfg_i.shape_kind == rmg_pkg::SHAPE_SPHERE) ? cfg_i.shape_kind
                                                         : rmg_pkg::SHAPE_CYL;
    if (cfg_i.ring_count == '0) begin
      rings_c = RB'(1);
    end else if (int'(cfg_i.ring_count) > MAX_RINGS) begin
      rings_c = RB'(MAX_RINGS);
    end else begin
      rings_c = RB'(cfg_i.ring_count);
    end
    na_c  = (kind_c == rmg_pkg::SHAPE_CONE) ? PB'(1) : len_q;
    per_c = {na_c - PB'(1), 1'b0};
  end

  always_comb begin
    rs    = {w_q.drem, w_q.dnum[DW-1]};
    ge    = rs >= {1'b0, w_q.dden};
    rem_n = ge ? DDW'(rs - {1'b0, w_q.dden}) : DDW'(rs);
    quo_n = {w_q.dquo[DW-2:0], ge};
    dlast = (w_q.dcnt == DCNT'(DW - 1));
  end

  always_comb begin
    sbit   = 32'd1 << (6'd30 - {1'b0, w_q.scnt, 1'b0});
    strial = w_q.sres + sbit;
  end

  always_comb begin
    in_sides = qx < w_q.sides;
    jn_w     = {1'b0, w_q.j} + (RB+1)'(1);
    jn       = (jn_w == {1'b0, w_q.rings}) ? '0 : RB'(jn_w);
    fo       = qx - w_q.sides;
    isbot    = w_q.bot && (fo < CW'(w_q.rings));
    fsel     = (w_q.bot && !isbot) ? fo - CW'(w_q.rings) : fo;
    found    = isbot || (w_q.top && (fsel < CW'(w_q.rings)));
    fselr    = RB'(fsel);
    fn_w     = {1'b0, fselr} + (RB+1)'(1);
    fn       = (fn_w == {1'b0, w_q.rings}) ? '0 : RB'(fn_w);
    m_a      = CW'(in_sides ? w_q.j : fselr) * CW'(w_q.na);
    m_b      = CW'(in_sides ? jn : fn) * CW'(w_q.na);
    ia       = CW'(w_q.i);
    off      = isbot ? '0 : CW'(w_q.na) - CW'(1);
    b_c      = rnd15(34'(w_q.pr1) - 34'(w_q.pr2));
    // cap height from the square root: negated and clamped at the bottom
    if (qx == w_q.nring) begin
      h_c = (w_q.sres >= 32'd32768) ? 16'sh8000 : -$signed(16'(w_q.sres));
    end else begin
      h_c = (w_q.sres > 32'd32767) ? 16'sh7fff : $signed(16'(w_q.sres));
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    w_d         = w_q;
    emit        = 1'b0;
    res_c       = '0;
    res_c.is_face = (w_q.cmd == rmg_pkg::CMD_FACE);

    unique case (state_q)
      S_IDLE: begin
        res_c.is_face = 1'b0;
        if (take) begin
          unique case (item_i.cmd)
            rmg_pkg::CMD_APPEND: begin
              emit = 1'b1;
              if (append_ok) begin
                len_d = len_q + PB'(1);
              end else begin
                res_c.status = rmg_pkg::ST_FULL;
              end
            end
            rmg_pkg::CMD_RESTART: begin
              emit  = 1'b1;
              len_d = '0;
            end
            default: begin
              w_d.cmd = item_i.cmd;
              w_d.qi  = item_i.query_index;
              state_d = S_SETUP;
            end
          endcase
        end
      end
      S_SETUP: begin
        w_d.kind      = kind_c;
        w_d.rings     = rings_c;
        w_d.na        = na_c;
        w_d.per       = per_c;
        w_d.nring     = CW'(na_c) * CW'(rings_c);
        w_d.sides     = CW'(rings_c) * CW'(per_c);
        w_d.bot       = (p0x_q != '0);
        w_d.top       = (kind_c == rmg_pkg::SHAPE_CONE) ? (p0x_q != '0) : (lastx_q != '0);
        w_d.too_short = (kind_c == rmg_pkg::SHAPE_CONE) ? (len_q < PB'(2)) : (len_q == '0);
        w_d.x0sq      = 32'(p0x_q * p0x_q);
        w_d.y0sq      = 32'(p0y_q * p0y_q);
        state_d       = S_ROUTE;
      end
      S_ROUTE: begin
        w_d.drem = '0;
        w_d.dquo = '0;
        w_d.dcnt = '0;
        w_d.dnum = DW'(w_q.qi);
        w_d.sv   = w_q.x0sq + w_q.y0sq;
        w_d.sres = '0;
        w_d.scnt = '0;
        if (w_q.too_short) begin
          emit         = 1'b1;
          res_c.status = rmg_pkg::ST_RANGE;
          state_d      = S_IDLE;
        end else if (w_q.cmd == rmg_pkg::CMD_FACE) begin
          if (in_sides) begin
            w_d.dden = DDW'(w_q.per);
            state_d  = S_DIVF;
          end else begin
            state_d  = S_FACE;
          end
        end else if (qx < w_q.nring) begin
          w_d.dden = DDW'(w_q.na);
          state_d  = S_DIVQ;
        end else if (qx == w_q.nring || qx == w_q.nring + CW'(1)) begin
          if ((qx == w_q.nring) ? !w_q.bot : !w_q.top) begin
            emit         = 1'b1;
            res_c.status = rmg_pkg::ST_NO_CAP;
            state_d      = S_IDLE;
          end else if (w_q.kind == rmg_pkg::SHAPE_SPHERE) begin
            state_d = S_SQRT;
          end else begin
            emit    = 1'b1;
            state_d = S_IDLE;
            {res_c.vx, res_c.vy, res_c.vz} = place(cfg_i.sweep_axis, '0, '0,
                (qx == w_q.nring) ? p0y_q :
                (w_q.kind == rmg_pkg::SHAPE_CONE) ? p1y_q : lasty_q);
          end
        end else begin
          emit         = 1'b1;
          res_c.status = rmg_pkg::ST_RANGE;
          state_d      = S_IDLE;
        end
      end
      S_DIVQ, S_DIVA, S_DIVF: begin
        w_d.drem = rem_n;
        w_d.dquo = quo_n;
        w_d.dnum = w_q.dnum << 1;
        w_d.dcnt = w_q.dcnt + DCNT'(1);
        if (dlast) begin
          w_d.drem = '0;
          w_d.dquo = '0;
          w_d.dcnt = '0;
          if (state_q == S_DIVQ) begin
            w_d.j    = RB'(quo_n);
            w_d.i    = IW'(rem_n);
            w_d.dnum = DW'({RB'(quo_n), {ANGLE_BITS{1'b0}}});
            w_d.dden = DDW'(w_q.rings);
            state_d  = S_DIVA;
          end else if (state_q == S_DIVA) begin
            w_d.p   = ANGLE_BITS'(quo_n);
            state_d = S_TRIG;
          end else begin
            w_d.j   = RB'(quo_n);
            w_d.i   = IW'(rem_n >> 1);
            w_d.par = rem_n[0];
            state_d = S_FACE;
          end
        end
      end
      S_TRIG: begin
        w_d.sn  = tsin(w_q.p);
        w_d.cs  = tsin(w_q.p + ANGLE_BITS'(2**QB));
        state_d = S_MUL1;
      end
      S_MUL1: begin
        w_d.pr1 = rd_q.px * w_q.cs;
        w_d.pr2 = rd_q.pz * w_q.sn;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        w_d.a   = rnd15(34'(w_q.pr1) + 34'(w_q.pr2));
        w_d.pr1 = rd_q.pz * w_q.cs;
        w_d.pr2 = rd_q.px * w_q.sn;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        {res_c.vx, res_c.vy, res_c.vz} = place(cfg_i.sweep_axis, w_q.a, b_c, rd_q.py);
      end
      S_SQRT: begin
        w_d.scnt = w_q.scnt + 4'd1;
        if (w_q.sv >= strial) begin
          w_d.sv   = w_q.sv - strial;
          w_d.sres = (w_q.sres >> 1) + sbit;
        end else begin
          w_d.sres = w_q.sres >> 1;
        end
        if (w_q.scnt == 4'd15) begin
          state_d = S_CAP;
        end
      end
      S_CAP: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        {res_c.vx, res_c.vy, res_c.vz} = place(cfg_i.sweep_axis, '0, '0, h_c);
      end
      S_FACE: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (in_sides) begin
          if (!w_q.par) begin
            res_c.corner_a = rmg_pkg::INDEX_W'(m_a + ia);
            res_c.corner_b = rmg_pkg::INDEX_W'(m_a + ia + CW'(1));
            res_c.corner_c = rmg_pkg::INDEX_W'(m_b + ia + CW'(1));
          end else begin
            res_c.corner_a = rmg_pkg::INDEX_W'(m_b + ia + CW'(1));
            res_c.corner_b = rmg_pkg::INDEX_W'(m_b + ia);
            res_c.corner_c = rmg_pkg::INDEX_W'(m_a + ia);
          end
        end else if (found) begin
          res_c.corner_a = rmg_pkg::INDEX_W'(isbot ? w_q.nring : w_q.nring + CW'(1));
          res_c.corner_b = rmg_pkg::INDEX_W'(m_a + off);
          res_c.corner_c = rmg_pkg::INDEX_W'(m_b + off);
        end else begin
          res_c.status = rmg_pkg::ST_RANGE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.cmd == rmg_pkg::CMD_APPEND && append_ok) begin
      mem[IW'(len_q)] <= item_i.pt;
      lastx_q         <= item_i.pt.px;
      lasty_q         <= item_i.pt.py;
      if (len_q == '0) begin
        p0x_q <= item_i.pt.px;
        p0y_q <= item_i.pt.py;
      end
      if (len_q == PB'(1)) begin
        p1y_q <= item_i.pt.py;
      end
    end
    rd_q  <= mem[w_q.i];
    w_q   <= w_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/revolution_mesh_generator.sv @@
// Mesh generator top level: configuration registers, input queue and execution side.
// Appends and restarts are answered from the idle state and may follow back to back while results are popped.
// A side vertex runs the shared one-bit-a-cycle divider twice over DW bits
// (DW = max(13, clog2(MAX_RINGS+1)+ANGLE_BITS)), then the sine lookup, rotation and placement.
// A sphere cap runs a 16-step square root; other caps are answered at routing; a side face runs the divider once.
// Reset empties both queues, clears the profile length and loads the register defaults.
`timescale 1ns / 1ps
module revolution_mesh_generator #(
  parameter int MAX_PROFILE = 64,
  parameter int MAX_RINGS   = 64,
  parameter int ANGLE_BITS  = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           cmd_i,
  input  logic signed [rmg_pkg::COORD_W-1:0]   px_i,
  input  logic signed [rmg_pkg::COORD_W-1:0]   py_i,
  input  logic signed [rmg_pkg::COORD_W-1:0]   pz_i,
  input  logic [rmg_pkg::INDEX_W-1:0]          query_index_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [1:0]                           status_o,
  output logic                                 is_face_o,
  output logic signed [rmg_pkg::COORD_W-1:0]   vx_o,
  output logic signed [rmg_pkg::COORD_W-1:0]   vy_o,
  output logic signed [rmg_pkg::COORD_W-1:0]   vz_o,
  output logic [rmg_pkg::INDEX_W-1:0]          corner_a_o,
  output logic [rmg_pkg::INDEX_W-1:0]          corner_b_o,
  output logic [rmg_pkg::INDEX_W-1:0]          corner_c_o,
  input  logic                                 cfg_we_i,
  input  logic [rmg_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rmg_pkg::CFG_W-1:0]            cfg_data_i
);

  rmg_pkg::cfg_t    cfg_q;
  rmg_pkg::item_t   item;
  rmg_pkg::result_t res;
  logic             item_valid, item_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_count <= rmg_pkg::RING_COUNT_RST;
      cfg_q.shape_kind <= rmg_pkg::SHAPE_KIND_RST;
      cfg_q.sweep_axis <= rmg_pkg::SWEEP_AXIS_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rmg_pkg::REG_RING_COUNT) begin
        cfg_q.ring_count <= cfg_data_i;
      end
      if (cfg_index_i == rmg_pkg::REG_SHAPE_KIND) begin
        cfg_q.shape_kind <= cfg_data_i[1:0];
      end
      if (cfg_index_i == rmg_pkg::REG_SWEEP_AXIS) begin
        cfg_q.sweep_axis <= cfg_data_i[1:0];
      end
    end
  end

  rmg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .px_i          (px_i),
    .py_i          (py_i),
    .pz_i          (pz_i),
    .query_index_i (query_index_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  rmg_back #(
    .MAX_PROFILE (MAX_PROFILE),
    .MAX_RINGS   (MAX_RINGS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (res)
  );

  assign status_o   = res.status;
  assign is_face_o  = res.is_face;
  assign vx_o       = res.vx;
  assign vy_o       = res.vy;
  assign vz_o       = res.vz;
  assign corner_a_o = res.corner_a;
  assign corner_b_o = res.corner_b;
  assign corner_c_o = res.corner_c;

  // an item is only started when the result slot is free or being drained
  a_take_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> (empty || pop))
    else $error("item started while result slot occupied");

  // appends and restarts answer in the next cycle
  a_append_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take && (item.cmd == rmg_pkg::CMD_APPEND || item.cmd == rmg_pkg::CMD_RESTART)
    |=> !empty)
    else $error("append or restart result missing");

  // only face results carry corner indices
  a_corners_face_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !is_face_o |-> (corner_a_o == '0 && corner_b_o == '0 && corner_c_o == '0))
    else $error("corner indices on a vertex result");

endmodule
